// ===== rtl/pfau_pkg.sv =====
`default_nettype none
package pfau_pkg;
  localparam int unsigned WIDTH_DEF = 32;
  localparam logic [31:0] MODULUS_RST = 32'd7;
  typedef enum logic [1:0] {
    CMD_ADD = 2'd0,
    CMD_SUB = 2'd1,
    CMD_MUL = 2'd2,
    CMD_NOP = 2'd3
  } cmd_t;
endpackage
`default_nettype wire

// ===== rtl/pfau_if.sv =====
`default_nettype none
interface pfau_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [31:0] operand_left;
  logic [31:0] operand_right;
  modport source (output valid, cmd, operand_left, operand_right, input ready);
  modport sink (input valid, cmd, operand_left, operand_right, output ready);
endinterface

interface pfau_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] remainder;
  modport source (output valid, remainder, input ready);
  modport sink (input valid, remainder, output ready);
endinterface
`default_nettype wire

// ===== rtl/prime_field_arithmetic_unit.sv =====
`default_nettype none
// Pipeline from input word to result word: a WIDTH-stage
// reduction pipeline for the operands, a registered sum, difference or
// product, a 2*WIDTH-stage reduction pipeline for the result, and the output register.
// Throughput: one word per cycle; the whole pipeline halts on output stall.
// Reset: synchronous active-low rst_n clears all valid bits and sets the
// modulus to 7.
module prime_field_arithmetic_unit #(
  parameter int unsigned WIDTH = pfau_pkg::WIDTH_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  cfg_we,
  input  wire logic [31:0] cfg_wdata,
  pfau_in_if.sink    in_ch,
  pfau_out_if.source out_ch
);
  localparam int unsigned W2 = 2 * WIDTH;
  localparam int unsigned L1 = WIDTH;      // operand reduction stages
  localparam int unsigned L2 = W2;         // result reduction stages
  localparam int unsigned LT = L1 + 1 + L2;

  logic [WIDTH-1:0] mod_r;
  logic             adv;
  logic             vld_r [LT+1];
  pfau_pkg::cmd_t   cmd_r [L1+1];
  logic             dgn_r [LT+1];
  logic             out_v_r;
  logic [WIDTH-1:0] out_d_r;

  // hold the modulus
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mod_r <= WIDTH'(pfau_pkg::MODULUS_RST);
    end else if (cfg_we) begin
      mod_r <= WIDTH'(cfg_wdata);
    end
  end

  assign adv         = !out_v_r || out_ch.ready;
  assign in_ch.ready = adv;

  // reduce both operands
  logic [WIDTH-1:0] la, ra, pa, pb;
  pfau_reduce #(.XW(WIDTH), .W(WIDTH)) u_rl (
    .clk(clk), .en(adv), .x(WIDTH'(in_ch.operand_left)), .p(mod_r),
    .r(la), .p_o(pa));
  pfau_reduce #(.XW(WIDTH), .W(WIDTH)) u_rr (
    .clk(clk), .en(adv), .x(WIDTH'(in_ch.operand_right)), .p(mod_r),
    .r(ra), .p_o(pb));

  always_comb begin
    vld_r[0] = in_ch.valid;
    cmd_r[0] = pfau_pkg::cmd_t'(in_ch.cmd);
    dgn_r[0] = (mod_r < WIDTH'(2));
  end

  genvar g;
  generate
    for (g = 0; g < LT; g++) begin : g_v
      logic v_q, d_q;
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          v_q <= 1'b0;
        end else if (adv) begin
          v_q <= vld_r[g];
        end
      end
      always_ff @(posedge clk) begin
        if (adv) begin
          d_q <= dgn_r[g];
        end
      end
      always_comb begin
        vld_r[g+1] = v_q;
        dgn_r[g+1] = d_q;
      end
    end
    for (g = 0; g < L1; g++) begin : g_c
      pfau_pkg::cmd_t c_q;
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          c_q <= pfau_pkg::CMD_NOP;
        end else if (adv) begin
          c_q <= cmd_r[g];
        end
      end
      always_comb cmd_r[g+1] = c_q;
    end
  endgenerate

  // combine reduced operands: add/sub as wide value, multiply as product
  logic [W2-1:0] comb_w, comb_r;
  logic [W2-1:0] lw, rw, pw;
  logic [WIDTH-1:0] p_r;
  assign lw = {{WIDTH{1'b0}}, la};
  assign rw = {{WIDTH{1'b0}}, ra};
  assign pw = {{WIDTH{1'b0}}, pa};
  always_comb begin
    unique case (cmd_r[L1])
      pfau_pkg::CMD_ADD: comb_w = lw + rw;
      pfau_pkg::CMD_SUB: comb_w = (la >= ra) ? lw - rw : lw + pw - rw;
      pfau_pkg::CMD_MUL: comb_w = lw * rw;
      default:           comb_w = '0;
    endcase
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      comb_r <= comb_w;
      p_r    <= pa;
    end
  end

  // reduce the combined value
  logic [WIDTH-1:0] res, pq;
  pfau_reduce #(.XW(W2), .W(WIDTH)) u_rf (
    .clk(clk), .en(adv), .x(comb_r), .p(p_r), .r(res), .p_o(pq));

  // drive the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= vld_r[LT];
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      out_d_r <= dgn_r[LT] ? '0 : res;
    end
  end

  assign out_ch.valid     = out_v_r;
  assign out_ch.remainder = 32'(out_d_r);

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && !out_ch.ready |=> out_v_r && $stable(out_d_r))
    else $error("result changed under stall");
  // result below modulus, zero for a degenerate modulus
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> ((mod_r < WIDTH'(2)) ? (out_d_r == '0) : (out_d_r < mod_r)))
    else $error("result not reduced");
  // modulus carried through the result reduction matches the register
  a_pq: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[LT] |-> pq == mod_r)
    else $error("result reduction modulus mismatch");
  // both operand reductions carry the same modulus
  a_pb: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[L1] |-> pb == pa)
    else $error("operand reduction modulus mismatch");
endmodule
`default_nettype wire

// ===== rtl/pfau_reduce.sv =====
`default_nettype none
// Registered wide reduction: x mod p via restoring subtract, one quotient
// bit per stage, used as a stallable pipeline of XW stages.
// Each stage: rem = rem >= (p << k) ? rem - (p << k) : rem, k from high to low.
module pfau_reduce #(
  parameter int unsigned XW = 64,
  parameter int unsigned W  = 32
) (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire logic [XW-1:0] x,
  input  wire logic [W-1:0]  p,
  output logic [W-1:0]       r,
  output logic [W-1:0]       p_o
);
  // Stage g subtracts p shifted left by XW-1-g, covering all quotient bits.
  localparam int unsigned NS = XW;
  logic [XW-1:0] rem_r [NS+1];
  logic [W-1:0]  pp_r  [NS+1];

  always_comb begin
    rem_r[0] = x;
    pp_r[0]  = p;
  end

  genvar g;
  generate
    for (g = 0; g < NS; g++) begin : g_st
      localparam int unsigned SH = NS - 1 - g;
      logic [XW+W-1:0] sub_w;
      logic [XW-1:0] rem_q;
      logic [W-1:0] pp_q;
      assign sub_w = {{W{1'b0}}, rem_r[g]} - ({{XW{1'b0}}, pp_r[g]} << SH);
      // advance one quotient bit
      always_ff @(posedge clk) begin
        if (en) begin
          rem_q <= sub_w[XW+W-1] ? rem_r[g] : sub_w[XW-1:0];
          pp_q  <= pp_r[g];
        end
      end
      always_comb begin
        rem_r[g+1] = rem_q;
        pp_r[g+1]  = pp_q;
      end
    end
  endgenerate

  assign r   = rem_r[NS][W-1:0];
  assign p_o = pp_r[NS];
endmodule
`default_nettype wire
